// ===== rtl/tnrx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnrx_pkg
// Shared types, telnet byte codes and option table for the telnet receive
// negotiator.
// ----------------------------------------------------------------------------
package tnrx_pkg;

    // Telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_NUL  = 8'd0;
    localparam logic [7:0] B_SEND = 8'd1;
    localparam logic [7:0] OPT_TTYPE = 8'd24;

    // Option table geometry
    localparam int NOPT = 4;

    // Option status codes
    localparam logic [1:0] ST_REQ   = 2'd0;
    localparam logic [1:0] ST_ACT   = 2'd1;
    localparam logic [1:0] ST_INACT = 2'd2;

    // Index of the last byte of the terminal-type reply
    localparam logic [3:0] TTYPE_LAST = 4'd10;

    // Opcode of an input transfer
    localparam logic OP_RX    = 1'b0;
    localparam logic OP_START = 1'b1;

    // Destination of an output byte
    localparam logic DEST_TERM = 1'b0;
    localparam logic DEST_NET  = 1'b1;

    // Parser states, one-hot
    typedef enum logic [9:0] {
        PS_TOP    = 10'b00_0000_0001,
        PS_IAC    = 10'b00_0000_0010,
        PS_WILL   = 10'b00_0000_0100,
        PS_WONT   = 10'b00_0000_1000,
        PS_DO     = 10'b00_0001_0000,
        PS_DONT   = 10'b00_0010_0000,
        PS_SB     = 10'b00_0100_0000,
        PS_SUB    = 10'b00_1000_0000,
        PS_SUBIAC = 10'b01_0000_0000,
        PS_CR     = 10'b10_0000_0000
    } t_pstate;

    // Kind of output burst
    typedef enum logic [1:0] {
        K_DATA  = 2'd0,  // one terminal byte
        K_REPLY = 2'd1,  // IAC cmd opt
        K_TTYPE = 2'd2,  // IAC SB TTYPE IS VT220 IAC SE
        K_START = 2'd3   // initial request of each entry in mask
    } t_kind;

    // Burst descriptor handed from parser to emitter
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       byte_a;   // data byte or reply command
        logic [7:0]       byte_b;   // reply option
        logic [NOPT-1:0]  mask;     // entries to request on start
    } t_desc;

    // Option table columns
    function automatic logic [7:0] opt_req(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = B_WILL;
            2'd1:    r = B_DO;
            2'd2:    r = B_WILL;
            default: r = B_DO;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] opt_nreq(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = B_WONT;
            2'd1:    r = B_DONT;
            2'd2:    r = B_WONT;
            default: r = B_DONT;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] opt_yes(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = B_DO;
            2'd1:    r = B_WILL;
            2'd2:    r = B_DO;
            default: r = B_WILL;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] opt_no(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = B_DONT;
            2'd1:    r = B_WONT;
            2'd2:    r = B_DONT;
            default: r = B_WONT;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] opt_code(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = OPT_TTYPE;
            2'd1:    r = 8'd1;
            2'd2:    r = 8'd3;
            default: r = 8'd3;
        endcase
        return r;
    endfunction

    // Terminal-type IS reply, byte by byte
    function automatic logic [7:0] ttype_byte(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = B_IAC;
            4'd1:    r = B_SB;
            4'd2:    r = OPT_TTYPE;
            4'd3:    r = 8'd0;    // IS
            4'd4:    r = 8'd86;   // V
            4'd5:    r = 8'd84;   // T
            4'd6:    r = 8'd50;   // 2
            4'd7:    r = 8'd50;   // 2
            4'd8:    r = 8'd48;   // 0
            4'd9:    r = B_IAC;
            4'd10:   r = B_SE;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tnrx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnrx_in_if / tnrx_out_if
// Valid/ready channels for received bytes in and terminal/network bytes out.
// ----------------------------------------------------------------------------
interface tnrx_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;
    logic       discard_data;

    modport source (output valid, output opcode, output rx_byte,
                    output discard_data, input ready);
    modport sink   (input valid, input opcode, input rx_byte,
                    input discard_data, output ready);
endinterface

interface tnrx_out_if;
    logic       valid;
    logic       ready;
    logic       dest;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output dest, output out_byte,
                    output last, input ready);
    modport sink   (input valid, input dest, input out_byte,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tnrx_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnrx_parser
// Telnet byte parser and option table. Registers a burst descriptor for the
// emitter, decoding one input transfer per cycle unless the slot stays full.
// ----------------------------------------------------------------------------
module tnrx_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    tnrx_in_if.sink               i_in,
    output tnrx_pkg::t_desc       o_desc,
    output logic                  o_desc_valid,
    input  wire                   i_desc_take
);

    tnrx_pkg::t_pstate r_state, n_state;
    logic [1:0]        r_opt [tnrx_pkg::NOPT];
    logic [1:0]        n_opt [tnrx_pkg::NOPT];
    logic [7:0]        r_sub_opt, n_sub_opt;
    logic [1:0]        r_sub_cnt, n_sub_cnt;
    logic [7:0]        r_sub_first, n_sub_first;
    tnrx_pkg::t_desc   r_desc, n_desc;
    logic              r_dv, n_dv;
    logic              w_acc;

    // Take a new item when the descriptor slot is free or being emptied
    assign i_in.ready   = !r_dv || i_desc_take;
    assign w_acc        = i_in.valid && i_in.ready;
    assign o_desc       = r_desc;
    assign o_desc_valid = r_dv;

    // Decode and next state
    always_comb begin
        logic [7:0] c;
        logic [7:0] cmd;
        logic       found;
        c           = i_in.rx_byte;
        cmd         = tnrx_pkg::B_WILL;
        found       = 1'b0;
        n_state     = r_state;
        n_opt       = r_opt;
        n_sub_opt   = r_sub_opt;
        n_sub_cnt   = r_sub_cnt;
        n_sub_first = r_sub_first;
        n_desc      = '0;
        n_dv        = 1'b0;

        if (i_in.opcode == tnrx_pkg::OP_START) begin
            // Initial requests for entries still pending
            n_desc.kind = tnrx_pkg::K_START;
            for (int i = 0; i < tnrx_pkg::NOPT; i++) begin
                n_desc.mask[i] = (r_opt[i] == tnrx_pkg::ST_REQ);
            end
            n_dv = |n_desc.mask;
        end else begin
            unique case (r_state)
                tnrx_pkg::PS_IAC: begin
                    priority if (c == tnrx_pkg::B_DO)   n_state = tnrx_pkg::PS_DO;
                    else if (c == tnrx_pkg::B_DONT)     n_state = tnrx_pkg::PS_DONT;
                    else if (c == tnrx_pkg::B_WILL)     n_state = tnrx_pkg::PS_WILL;
                    else if (c == tnrx_pkg::B_WONT)     n_state = tnrx_pkg::PS_WONT;
                    else if (c == tnrx_pkg::B_SB)       n_state = tnrx_pkg::PS_SB;
                    else                                n_state = tnrx_pkg::PS_TOP;
                end
                tnrx_pkg::PS_WILL, tnrx_pkg::PS_WONT,
                tnrx_pkg::PS_DO, tnrx_pkg::PS_DONT: begin
                    unique case (r_state)
                        tnrx_pkg::PS_WILL: cmd = tnrx_pkg::B_WILL;
                        tnrx_pkg::PS_WONT: cmd = tnrx_pkg::B_WONT;
                        tnrx_pkg::PS_DO:   cmd = tnrx_pkg::B_DO;
                        default:           cmd = tnrx_pkg::B_DONT;
                    endcase
                    n_desc.kind   = tnrx_pkg::K_REPLY;
                    n_desc.byte_b = c;
                    // First entry whose option and command both match wins
                    for (int i = 0; i < tnrx_pkg::NOPT; i++) begin
                        if (!found && tnrx_pkg::opt_code(2'(i)) == c) begin
                            if (tnrx_pkg::opt_yes(2'(i)) == cmd) begin
                                found         = 1'b1;
                                n_desc.byte_a = tnrx_pkg::opt_req(2'(i));
                                n_dv          = (r_opt[i] != tnrx_pkg::ST_REQ) &&
                                                (r_opt[i] != tnrx_pkg::ST_ACT);
                                n_opt[i]      = tnrx_pkg::ST_ACT;
                            end else if (tnrx_pkg::opt_no(2'(i)) == cmd) begin
                                found         = 1'b1;
                                n_desc.byte_a = tnrx_pkg::opt_nreq(2'(i));
                                n_dv          = (r_opt[i] == tnrx_pkg::ST_ACT);
                                n_opt[i]      = tnrx_pkg::ST_INACT;
                            end
                        end
                    end
                    // Refuse anything not in the table
                    if (!found) begin
                        n_desc.byte_a = (cmd == tnrx_pkg::B_WILL) ?
                                        tnrx_pkg::B_DONT : tnrx_pkg::B_WONT;
                        n_dv          = 1'b1;
                    end
                    n_state = tnrx_pkg::PS_TOP;
                end
                tnrx_pkg::PS_SB: begin
                    n_sub_opt = c;
                    n_sub_cnt = 2'd0;
                    n_state   = tnrx_pkg::PS_SUB;
                end
                tnrx_pkg::PS_SUB, tnrx_pkg::PS_SUBIAC: begin
                    if (r_state == tnrx_pkg::PS_SUB && c == tnrx_pkg::B_IAC) begin
                        n_state = tnrx_pkg::PS_SUBIAC;
                    end else if (r_state == tnrx_pkg::PS_SUBIAC &&
                                 c == tnrx_pkg::B_SE) begin
                        // End of subnegotiation: answer terminal-type SEND
                        n_desc.kind = tnrx_pkg::K_TTYPE;
                        n_dv        = (r_sub_opt == tnrx_pkg::OPT_TTYPE) &&
                                      (r_sub_cnt == 2'd1) &&
                                      (r_sub_first == tnrx_pkg::B_SEND);
                        n_state     = tnrx_pkg::PS_TOP;
                    end else begin
                        // Data byte: keep first, count saturates at two
                        if (r_sub_cnt == 2'd0) n_sub_first = c;
                        if (r_sub_cnt != 2'd2) n_sub_cnt = r_sub_cnt + 2'd1;
                        n_state = tnrx_pkg::PS_SUB;
                    end
                end
                default: begin
                    // Top level and after CR
                    priority if (c == tnrx_pkg::B_NUL && r_state == tnrx_pkg::PS_CR) begin
                        n_state = tnrx_pkg::PS_TOP;
                    end else if (c == tnrx_pkg::B_IAC) begin
                        n_state = tnrx_pkg::PS_IAC;
                    end else begin
                        n_desc.kind   = tnrx_pkg::K_DATA;
                        n_desc.byte_a = c;
                        n_dv          = !i_in.discard_data;
                        n_state       = (c == tnrx_pkg::B_CR) ?
                                        tnrx_pkg::PS_CR : tnrx_pkg::PS_TOP;
                    end
                end
            endcase
        end
    end

    // Parser state and option table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tnrx_pkg::PS_TOP;
            r_sub_opt   <= 8'd0;
            r_sub_cnt   <= 2'd0;
            r_sub_first <= 8'd0;
            for (int i = 0; i < tnrx_pkg::NOPT; i++) begin
                r_opt[i] <= tnrx_pkg::ST_REQ;
            end
        end else if (w_acc) begin
            r_state     <= n_state;
            r_sub_opt   <= n_sub_opt;
            r_sub_cnt   <= n_sub_cnt;
            r_sub_first <= n_sub_first;
            r_opt       <= n_opt;
        end
    end

    // Descriptor slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_acc) begin
            r_dv <= n_dv;
        end else if (i_desc_take) begin
            r_dv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= '0;
        end else if (w_acc) begin
            r_desc <= n_desc;
        end
    end

    // Checks
    a_sub_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub_cnt != 2'd3)
        else $error("subnegotiation count beyond saturation");
    a_start_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.opcode == tnrx_pkg::OP_START) |=> $stable(r_state))
        else $error("start command changed parser state");
    a_desc_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv && !i_desc_take) |=> (r_dv && $stable(r_desc)))
        else $error("pending descriptor lost");

endmodule
`default_nettype wire

// ===== rtl/tnrx_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnrx_emitter
// Holds one burst descriptor and sends its bytes, one output transfer per
// cycle while the receiver is ready, flagging the final byte of each burst.
// ----------------------------------------------------------------------------
module tnrx_emitter (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tnrx_pkg::t_desc       i_desc,
    input  wire                   i_desc_valid,
    output logic                  o_desc_take,
    tnrx_out_if.source            o_out
);

    logic                      r_busy;
    tnrx_pkg::t_desc           r_desc;
    logic [3:0]                r_idx;
    logic [tnrx_pkg::NOPT-1:0] r_mask;
    logic [tnrx_pkg::NOPT-1:0] w_low;
    logic [tnrx_pkg::NOPT-1:0] w_rest;
    logic [1:0]                w_ent;
    logic [7:0]                w_byte;
    logic                      w_last;

    // Lowest pending entry of a start burst
    assign w_low  = r_mask & (~r_mask + 1'b1);
    assign w_rest = r_mask & ~w_low;

    always_comb begin
        w_ent = 2'd0;
        for (int i = tnrx_pkg::NOPT - 1; i >= 0; i--) begin
            if (w_low[i]) w_ent = 2'(i);
        end
    end

    // Byte select and last flag
    always_comb begin
        w_byte = tnrx_pkg::B_IAC;
        w_last = 1'b0;
        unique case (r_desc.kind)
            tnrx_pkg::K_DATA: begin
                w_byte = r_desc.byte_a;
                w_last = 1'b1;
            end
            tnrx_pkg::K_REPLY: begin
                if (r_idx == 4'd1)      w_byte = r_desc.byte_a;
                else if (r_idx == 4'd2) w_byte = r_desc.byte_b;
                w_last = (r_idx == 4'd2);
            end
            tnrx_pkg::K_TTYPE: begin
                w_byte = tnrx_pkg::ttype_byte(r_idx);
                w_last = (r_idx == tnrx_pkg::TTYPE_LAST);
            end
            tnrx_pkg::K_START: begin
                if (r_idx == 4'd1)      w_byte = tnrx_pkg::opt_req(w_ent);
                else if (r_idx == 4'd2) w_byte = tnrx_pkg::opt_code(w_ent);
                w_last = (r_idx == 4'd2) && (w_rest == '0);
            end
        endcase
    end

    assign o_out.valid    = r_busy;
    assign o_out.dest     = (r_desc.kind == tnrx_pkg::K_DATA) ?
                            tnrx_pkg::DEST_TERM : tnrx_pkg::DEST_NET;
    assign o_out.out_byte = w_byte;
    assign o_out.last     = w_last;
    assign o_desc_take    = !r_busy || (o_out.ready && w_last);

    // Burst sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_desc_take) begin
            r_busy <= i_desc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_take) begin
            r_desc <= i_desc;
            r_idx  <= 4'd0;
            r_mask <= i_desc.mask;
        end else if (o_out.ready) begin
            if (r_desc.kind == tnrx_pkg::K_START && r_idx == 4'd2) begin
                r_idx  <= 4'd0;
                r_mask <= w_rest;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // Checks
    a_start_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_desc.kind == tnrx_pkg::K_START) |-> (r_mask != '0))
        else $error("start burst with no pending entry");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_desc.kind != tnrx_pkg::K_TTYPE) |-> (r_idx <= 4'd2))
        else $error("reply index out of range");
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && o_out.ready && !w_last) |=> r_busy)
        else $error("burst ended without last byte");

endmodule
`default_nettype wire

// ===== rtl/telnet_receive_negotiator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: the parser's descriptor register, then the emitter's burst register.
// Throughput: one input transfer per cycle while each causes at most one byte
// and the receiver is ready; an item causing 3, 11 or up to 12 bytes keeps the
// emitter busy. The output byte stream limits it: one byte per cycle if ready.
// Reset: synchronous active-low; parser at top level, all options requested.
// ----------------------------------------------------------------------------
// telnet_receive_negotiator_unit
// Telnet receive side: splits terminal data from IAC commands, tracks four
// option entries and sends negotiation replies toward the network.
// ----------------------------------------------------------------------------
module telnet_receive_negotiator_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tnrx_in_if.sink    i_in,
    tnrx_out_if.source o_out
);

    tnrx_pkg::t_desc w_desc;
    logic            w_desc_valid;
    logic            w_desc_take;

    // Parser and option table
    tnrx_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_desc       (w_desc),
        .o_desc_valid (w_desc_valid),
        .i_desc_take  (w_desc_take)
    );

    // Byte sequencer
    tnrx_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_desc),
        .i_desc_valid (w_desc_valid),
        .o_desc_take  (w_desc_take),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_telnet_receive_negotiator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_telnet_receive_negotiator_unit
// Self-checking bench for the telnet receive negotiator. A scoreboard class
// tracks its own parser state and option table. For every input transfer it
// works out the terminal and network bytes that should follow, and it checks
// each output transfer against them in order. Stimulus is a directed opening,
// then random telnet sequences (data, CR, commands, negotiation,
// subnegotiation, start) mixed with noise. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_telnet_receive_negotiator_unit;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TARGET = 350;
    localparam int DRAIN_EVERY = 120;
    localparam int TAIL_CYCLES = 20;

    // Option numbers outside the terminal-type one
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    // Terminal-type IS code
    localparam logic [7:0] TT_IS    = 8'd0;
    // A command with no meaning to the parser (NOP)
    localparam logic [7:0] CMD_NOP  = 8'd241;

    // Option entries: code, request, negative request, accept, refuse
    localparam logic [7:0] ENTRY_CODE [tnrx_pkg::NOPT] =
        '{tnrx_pkg::OPT_TTYPE, OPT_ECHO, OPT_SGA, OPT_SGA};
    localparam logic [7:0] ENTRY_REQ  [tnrx_pkg::NOPT] =
        '{tnrx_pkg::B_WILL, tnrx_pkg::B_DO, tnrx_pkg::B_WILL, tnrx_pkg::B_DO};
    localparam logic [7:0] ENTRY_NREQ [tnrx_pkg::NOPT] =
        '{tnrx_pkg::B_WONT, tnrx_pkg::B_DONT, tnrx_pkg::B_WONT, tnrx_pkg::B_DONT};
    localparam logic [7:0] ENTRY_YES  [tnrx_pkg::NOPT] =
        '{tnrx_pkg::B_DO, tnrx_pkg::B_WILL, tnrx_pkg::B_DO, tnrx_pkg::B_WILL};
    localparam logic [7:0] ENTRY_NO   [tnrx_pkg::NOPT] =
        '{tnrx_pkg::B_DONT, tnrx_pkg::B_WONT, tnrx_pkg::B_DONT, tnrx_pkg::B_WONT};

    // IAC SB TTYPE IS "VT220" IAC SE
    localparam logic [7:0] TTYPE_IS [11] = '{tnrx_pkg::B_IAC, tnrx_pkg::B_SB,
        tnrx_pkg::OPT_TTYPE, TT_IS, 8'h56, 8'h54, 8'h32, 8'h32, 8'h30,
        tnrx_pkg::B_IAC, tnrx_pkg::B_SE};

    typedef struct {
        logic       dest;
        logic [7:0] val;
        logic       last;
    } t_tn_byte;

    // ------------------------------------------------------------------------
    // Scoreboard: own parser, option table and queue of expected bytes
    // ------------------------------------------------------------------------
    class telnet_byte_scoreboard;
        tnrx_pkg::t_pstate pstate;
        logic [1:0] opt_st [tnrx_pkg::NOPT];
        logic [7:0] sub_opt;
        logic [1:0] sub_cnt;
        logic [7:0] sub_first;
        t_tn_byte   pending_bytes [$];
        int         mismatches;

        function new();
            pstate     = tnrx_pkg::PS_TOP;
            foreach (opt_st[i]) opt_st[i] = tnrx_pkg::ST_REQ;
            sub_opt    = 8'd0;
            sub_cnt    = 2'd0;
            sub_first  = 8'd0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        function void push_byte(logic dest, logic [7:0] val);
            t_tn_byte b;
            b.dest = dest;
            b.val  = val;
            b.last = 1'b0;
            pending_bytes.push_back(b);
        endfunction

        function void push_reply(logic [7:0] cmd, logic [7:0] opt);
            push_byte(tnrx_pkg::DEST_NET, tnrx_pkg::B_IAC);
            push_byte(tnrx_pkg::DEST_NET, cmd);
            push_byte(tnrx_pkg::DEST_NET, opt);
        endfunction

        // WILL/WONT/DO/DONT against the option table
        function void negotiate(logic [7:0] cmd, logic [7:0] opt);
            for (int i = 0; i < tnrx_pkg::NOPT; i++) begin
                if (ENTRY_CODE[i] != opt)
                    continue;
                if (ENTRY_YES[i] == cmd) begin
                    if (opt_st[i] != tnrx_pkg::ST_REQ && opt_st[i] != tnrx_pkg::ST_ACT)
                        push_reply(ENTRY_REQ[i], opt);
                    opt_st[i] = tnrx_pkg::ST_ACT;
                    return;
                end
                if (ENTRY_NO[i] == cmd) begin
                    if (opt_st[i] == tnrx_pkg::ST_ACT)
                        push_reply(ENTRY_NREQ[i], opt);
                    opt_st[i] = tnrx_pkg::ST_INACT;
                    return;
                end
            end
            // no entry takes it: refuse
            push_reply((cmd == tnrx_pkg::B_WILL) ? tnrx_pkg::B_DONT : tnrx_pkg::B_WONT,
                       opt);
        endfunction

        function void add_sub_byte(logic [7:0] c);
            if (sub_cnt == 2'd0)
                sub_first = c;
            if (sub_cnt < 2'd2)
                sub_cnt = sub_cnt + 2'd1;
            pstate = tnrx_pkg::PS_SUB;
        endfunction

        // Accepted input: advance the parser and queue the bytes it causes
        function void note_transfer(logic op, logic [7:0] c, logic disc);
            int first;
            first = pending_bytes.size();
            if (op == tnrx_pkg::OP_START) begin
                for (int i = 0; i < tnrx_pkg::NOPT; i++)
                    if (opt_st[i] == tnrx_pkg::ST_REQ)
                        push_reply(ENTRY_REQ[i], ENTRY_CODE[i]);
            end else begin
                case (pstate)
                    tnrx_pkg::PS_IAC: begin
                        if (c == tnrx_pkg::B_DO)        pstate = tnrx_pkg::PS_DO;
                        else if (c == tnrx_pkg::B_DONT) pstate = tnrx_pkg::PS_DONT;
                        else if (c == tnrx_pkg::B_WILL) pstate = tnrx_pkg::PS_WILL;
                        else if (c == tnrx_pkg::B_WONT) pstate = tnrx_pkg::PS_WONT;
                        else if (c == tnrx_pkg::B_SB)   pstate = tnrx_pkg::PS_SB;
                        else                            pstate = tnrx_pkg::PS_TOP;
                    end
                    tnrx_pkg::PS_WILL: begin
                        negotiate(tnrx_pkg::B_WILL, c);
                        pstate = tnrx_pkg::PS_TOP;
                    end
                    tnrx_pkg::PS_WONT: begin
                        negotiate(tnrx_pkg::B_WONT, c);
                        pstate = tnrx_pkg::PS_TOP;
                    end
                    tnrx_pkg::PS_DO: begin
                        negotiate(tnrx_pkg::B_DO, c);
                        pstate = tnrx_pkg::PS_TOP;
                    end
                    tnrx_pkg::PS_DONT: begin
                        negotiate(tnrx_pkg::B_DONT, c);
                        pstate = tnrx_pkg::PS_TOP;
                    end
                    tnrx_pkg::PS_SB: begin
                        sub_opt = c;
                        sub_cnt = 2'd0;
                        pstate  = tnrx_pkg::PS_SUB;
                    end
                    tnrx_pkg::PS_SUB: begin
                        if (c == tnrx_pkg::B_IAC)
                            pstate = tnrx_pkg::PS_SUBIAC;
                        else
                            add_sub_byte(c);
                    end
                    tnrx_pkg::PS_SUBIAC: begin
                        if (c != tnrx_pkg::B_SE) begin
                            add_sub_byte(c);
                        end else begin
                            // only a lone SEND for terminal type gets an answer
                            if (sub_opt == tnrx_pkg::OPT_TTYPE && sub_cnt == 2'd1 &&
                                sub_first == tnrx_pkg::B_SEND)
                                foreach (TTYPE_IS[k])
                                    push_byte(tnrx_pkg::DEST_NET, TTYPE_IS[k]);
                            pstate = tnrx_pkg::PS_TOP;
                        end
                    end
                    default: begin
                        if (c == tnrx_pkg::B_NUL && pstate == tnrx_pkg::PS_CR) begin
                            pstate = tnrx_pkg::PS_TOP;
                        end else if (c == tnrx_pkg::B_IAC) begin
                            pstate = tnrx_pkg::PS_IAC;
                        end else begin
                            if (!disc)
                                push_byte(tnrx_pkg::DEST_TERM, c);
                            pstate = (c == tnrx_pkg::B_CR) ? tnrx_pkg::PS_CR :
                                                             tnrx_pkg::PS_TOP;
                        end
                    end
                endcase
            end
            if (pending_bytes.size() > first)
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s", $time, msg);
        endfunction

        // Accepted output: compare with the oldest expected byte
        function void check_byte(logic dest, logic [7:0] val, logic last);
            t_tn_byte exp_b;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected byte: dest=%0d byte=%02h last=%0d",
                                 dest, val, last));
                return;
            end
            exp_b = pending_bytes.pop_front();
            if (exp_b.dest !== dest || exp_b.val !== val || exp_b.last !== last)
                report($sformatf({"byte mismatch: expected dest=%0d byte=%02h last=%0d,",
                                  " got dest=%0d byte=%02h last=%0d"},
                                 exp_b.dest, exp_b.val, exp_b.last, dest, val, last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tnrx_in_if  in_ch ();
    tnrx_out_if out_ch ();

    telnet_receive_negotiator_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    telnet_byte_scoreboard sb;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;
    logic [7:0] ready_phase = 8'd0;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_transfer(in_ch.opcode, in_ch.rx_byte, in_ch.discard_data);
            if (out_ch.valid && out_ch.ready)
                sb.check_byte(out_ch.dest, out_ch.out_byte, out_ch.last);
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall pattern: free, coin flip, 3 of 4, mostly stalled
    always @(negedge clk) begin
        ready_phase = ready_phase + 8'd1;
        case (ready_phase[7:6])
            2'd0:    out_ch.ready = 1'b1;
            2'd1:    out_ch.ready = 1'($urandom_range(0, 1));
            2'd2:    out_ch.ready = (ready_phase[1:0] != 2'd3);
            default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic rand_disc();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // One input transfer, with burst/gap idling in front of it
    task automatic send_transfer(logic op, logic [7:0] b, logic disc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                in_ch.valid   = 1'b0;
                in_ch.rx_byte = 8'($urandom_range(0, 255));
            end
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid        = 1'b1;
        in_ch.opcode       = op;
        in_ch.rx_byte      = b;
        in_ch.discard_data = disc;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic rx(logic [7:0] b, logic disc = 1'b0);
        send_transfer(tnrx_pkg::OP_RX, b, disc);
    endtask

    task automatic start_cmd();
        send_transfer(tnrx_pkg::OP_START, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every expected byte has come out
    task automatic wait_drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    task automatic negotiation_seq();
        logic [7:0] cmd;
        logic [7:0] opt;
        case ($urandom_range(0, 3))
            0:       cmd = tnrx_pkg::B_WILL;
            1:       cmd = tnrx_pkg::B_WONT;
            2:       cmd = tnrx_pkg::B_DO;
            default: cmd = tnrx_pkg::B_DONT;
        endcase
        case ($urandom_range(0, 3))
            0:       opt = tnrx_pkg::OPT_TTYPE;
            1:       opt = OPT_ECHO;
            2:       opt = OPT_SGA;
            default: opt = 8'($urandom_range(0, 255));
        endcase
        rx(tnrx_pkg::B_IAC, rand_disc());
        rx(cmd, rand_disc());
        rx(opt, rand_disc());
    endtask

    task automatic sub_seq();
        int n;
        logic [7:0] b;
        rx(tnrx_pkg::B_IAC, rand_disc());
        rx(tnrx_pkg::B_SB, rand_disc());
        rx(($urandom_range(0, 3) != 0) ? tnrx_pkg::OPT_TTYPE : 8'($urandom_range(0, 255)),
           rand_disc());
        n = $urandom_range(0, 1) ? 1 : $urandom_range(0, 4);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                // IAC followed by anything but SE stays in the subnegotiation
                b = 8'($urandom_range(0, 255));
                if (b == tnrx_pkg::B_SE)
                    b = tnrx_pkg::B_IAC;
                rx(tnrx_pkg::B_IAC, rand_disc());
                rx(b, rand_disc());
            end else begin
                b = (k == 0 && $urandom_range(0, 1)) ? tnrx_pkg::B_SEND :
                                                       8'($urandom_range(0, 254));
                rx(b, rand_disc());
            end
        end
        // now and then leave it unterminated
        if ($urandom_range(0, 9) != 0) begin
            rx(tnrx_pkg::B_IAC, rand_disc());
            rx(tnrx_pkg::B_SE, rand_disc());
        end
    endtask

    task automatic random_seq();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            n = $urandom_range(1, 6);
            repeat (n) rx(8'($urandom_range(0, 254)), rand_disc());
        end else if (kind < 38) begin
            rx(tnrx_pkg::B_CR, rand_disc());
            case ($urandom_range(0, 2))
                0:       rx(tnrx_pkg::B_NUL, rand_disc());
                1:       rx(8'($urandom_range(0, 255)), rand_disc());
                default: rx(tnrx_pkg::B_CR, rand_disc());
            endcase
        end else if (kind < 48) begin
            rx(tnrx_pkg::B_IAC, rand_disc());
            rx(8'($urandom_range(0, 255)), rand_disc());
        end else if (kind < 75) begin
            negotiation_seq();
        end else if (kind < 88) begin
            sub_seq();
        end else if (kind < 93) begin
            start_cmd();
        end else begin
            send_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int next_drain;
        sb = new();
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = tnrx_pkg::OP_RX;
        in_ch.rx_byte      = 8'd0;
        in_ch.discard_data = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening
        start_cmd();                                   // all four requests
        rx(tnrx_pkg::B_NUL);                           // NUL at top level is data
        rx(8'hFE);
        rx(tnrx_pkg::B_CR, 1'b1);                      // CR suppressed by discard
        rx(tnrx_pkg::B_NUL);                           // NUL after CR dropped
        rx(tnrx_pkg::B_IAC); rx(tnrx_pkg::B_IAC);      // IAC IAC ignored
        rx(tnrx_pkg::B_IAC); rx(CMD_NOP);              // other command ignored
        // requested -> inactive, silent
        rx(tnrx_pkg::B_IAC); rx(tnrx_pkg::B_DONT); rx(tnrx_pkg::OPT_TTYPE);
        start_cmd();                                   // three requests left
        // inactive -> active, WILL reply
        rx(tnrx_pkg::B_IAC); rx(tnrx_pkg::B_DO); rx(tnrx_pkg::OPT_TTYPE);
        // unknown option refused
        rx(tnrx_pkg::B_IAC); rx(tnrx_pkg::B_WILL); rx(8'd200);
        rx(tnrx_pkg::B_IAC); rx(tnrx_pkg::B_SB); rx(tnrx_pkg::OPT_TTYPE);
        rx(tnrx_pkg::B_SEND);
        rx(tnrx_pkg::B_IAC); rx(tnrx_pkg::B_SE);       // terminal-type SEND answered
        wait_drain();

        // Random sequences
        next_drain = items_sent + DRAIN_EVERY;
        while (items_sent < ITEM_TARGET) begin
            random_seq();
            if (items_sent >= next_drain) begin
                wait_drain();
                next_drain = items_sent + DRAIN_EVERY;
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
